[rtl/dls_pkg.sv]
// Shared types, codes and sizes for the delta list task scheduler.
package dls_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   // request actions
   localparam logic [1:0] ACT_ADD      = 2'd0;
   localparam logic [1:0] ACT_DELETE   = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;
   localparam logic [1:0] ACT_DISPATCH = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
   localparam logic [1:0] ST_DISPATCHED = 2'd3;

   // one list entry as held in the slot memory
   typedef struct packed {
      logic [7:0]  handle;
      logic [31:0] id;
      logic [31:0] delta;
      logic [31:0] period;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

[rtl/dls_ram.sv]
// Generic single write port, single read port RAM with registered read.
module dls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/delta_list_task_scheduler_top.sv]
// Delta list timer queue: sequencer around one slot memory holding the list.
//
// The list lives in one memory in due order, head at slot 0; each step reads
// one slot through the registered read port, and the shifting steps then
// write one back, so the memory port sets the pace. Add walks up to the
// insertion point and shifts the tail up. Delete walks to the match and
// shifts the tail down. Tick counts the head delta down unless it is zero.
// Dispatch removes each due task from the head, plus an add pass for each
// periodic one. busy is high from the cycle after acceptance until the cycle
// in which the item ends, which shows its last word if it has one (a dispatch
// with nothing due shows none); an add refused on a full table is answered
// from idle and leaves busy low. Each result word sits on the rsp_ ports for
// one cycle with rsp_strobe high and cannot be held off by the receiver.
module delta_list_task_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_task_handle,
   input  logic [31:0] req_start_delay,
   input  logic [31:0] req_repeat_period,
   input  logic [31:0] req_target_id,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_id,
   output logic [7:0]  rsp_run_handle,
   output logic        rsp_last_of_run
);

   import dls_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_AW_RD  = 14'b00000000000010,
      S_AW_CHK = 14'b00000000000100,
      S_AS_RD  = 14'b00000000001000,
      S_AS_WR  = 14'b00000000010000,
      S_A_NEW  = 14'b00000000100000,
      S_DF_RD  = 14'b00000001000000,
      S_DF_CHK = 14'b00000010000000,
      S_RM_RD  = 14'b00000100000000,
      S_RM_WR  = 14'b00001000000000,
      S_TK_RD  = 14'b00010000000000,
      S_TK_WR  = 14'b00100000000000,
      S_DP_RD  = 14'b01000000000000,
      S_DP_CHK = 14'b10000000000000
   } state_type;

   state_type      state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]    next_id_ff, next_id_in;
   logic [1:0]     act_ff, act_in;
   logic [7:0]     handle_ff, handle_in;
   logic [31:0]    delay_ff, delay_in;
   logic [31:0]    period_ff, period_in;
   logic [31:0]    target_ff, target_in;
   logic [31:0]    new_id_ff, new_id_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [31:0]    sum_ff, sum_in;
   logic [31:0]    nd_ff, nd_in;
   logic           pend_valid_ff, pend_valid_in;
   logic [31:0]    pend_id_ff, pend_id_in;
   logic [7:0]     pend_handle_ff, pend_handle_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_result_id_ff, rsp_result_id_in;
   logic [7:0]     rsp_run_handle_ff, rsp_run_handle_in;
   logic           rsp_last_ff, rsp_last_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   slot_entry_type     ram_wr_entry;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   slot_entry_type     rd_entry;
   logic [32:0]        sum_tot;
   logic [32:0]        delay_ext;
   logic [CNT_W-1:0]   pos_next;

   assign rd_entry  = slot_entry_type'(ram_rd_data);
   assign sum_tot   = {1'b0, sum_ff} + {1'b0, rd_entry.delta};
   assign delay_ext = {1'b0, delay_ff};
   assign pos_next  = pos_ff + CNT_W'(1);

   dls_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_TASKS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ENTRY_W'(ram_wr_entry)),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // sequence the list operations over the slot memory
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      next_id_in        = next_id_ff;
      act_in            = act_ff;
      handle_in         = handle_ff;
      delay_in          = delay_ff;
      period_in         = period_ff;
      target_in         = target_ff;
      new_id_in         = new_id_ff;
      idx_in            = idx_ff;
      pos_in            = pos_ff;
      sum_in            = sum_ff;
      nd_in             = nd_ff;
      pend_valid_in     = pend_valid_ff;
      pend_id_in        = pend_id_ff;
      pend_handle_in    = pend_handle_ff;
      rsp_strobe_in     = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_result_id_in  = rsp_result_id_ff;
      rsp_run_handle_in = rsp_run_handle_ff;
      rsp_last_in       = rsp_last_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = '0;
      ram_wr_entry      = rd_entry;
      ram_rd_en         = 1'b0;
      ram_rd_addr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in    = req_action;
               handle_in = req_task_handle;
               delay_in  = req_start_delay;
               period_in = req_repeat_period;
               target_in = req_target_id;
               idx_in    = '0;
               sum_in    = '0;
               unique case (req_action)
                  ACT_ADD: begin
                     if (count_ff == CNT_W'(MAX_TASKS)) begin
                        rsp_strobe_in     = 1'b1;
                        rsp_status_in     = ST_FULL;
                        rsp_result_id_in  = '0;
                        rsp_run_handle_in = '0;
                        rsp_last_in       = 1'b1;
                     end else begin
                        new_id_in  = next_id_ff;
                        next_id_in = next_id_ff + 32'd1;
                        state_in   = S_AW_RD;
                     end
                  end
                  ACT_DELETE:   state_in = S_DF_RD;
                  ACT_TICK:     state_in = S_TK_RD;
                  ACT_DISPATCH: state_in = S_DP_RD;
                  default:      state_in = S_IDLE;
               endcase
            end
         end

         // walk the list for the insertion point
         S_AW_RD: begin
            if (idx_ff >= count_ff) begin
               pos_in   = count_ff;
               nd_in    = delay_ff - sum_ff;
               idx_in   = count_ff;
               state_in = S_AS_RD;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff[IDX_W-1:0];
               state_in    = S_AW_CHK;
            end
         end

         S_AW_CHK: begin
            if (delay_ext < sum_tot) begin
               pos_in   = idx_ff;
               nd_in    = delay_ff - sum_ff;
               idx_in   = count_ff;
               state_in = S_AS_RD;
            end else if (delay_ext == sum_tot) begin
               pos_in   = idx_ff + CNT_W'(1);
               nd_in    = '0;
               idx_in   = count_ff;
               state_in = S_AS_RD;
            end else begin
               sum_in   = sum_tot[31:0];
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_AW_RD;
            end
         end

         // shift the tail up by one slot
         S_AS_RD: begin
            if (idx_ff == pos_ff) begin
               state_in = S_A_NEW;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_W'(idx_ff - CNT_W'(1));
               state_in    = S_AS_WR;
            end
         end

         S_AS_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff[IDX_W-1:0];
            if (idx_ff == pos_next) begin
               ram_wr_entry.delta = rd_entry.delta - nd_ff;
            end
            idx_in   = idx_ff - CNT_W'(1);
            state_in = S_AS_RD;
         end

         // write the new entry into the gap
         S_A_NEW: begin
            ram_wr_en           = 1'b1;
            ram_wr_addr         = pos_ff[IDX_W-1:0];
            ram_wr_entry.handle = handle_ff;
            ram_wr_entry.id     = new_id_ff;
            ram_wr_entry.delta  = nd_ff;
            ram_wr_entry.period = period_ff;
            count_in            = count_ff + CNT_W'(1);
            if (act_ff == ACT_DISPATCH) begin
               state_in = S_DP_RD;
            end else begin
               rsp_strobe_in     = 1'b1;
               rsp_status_in     = ST_OK;
               rsp_result_id_in  = new_id_ff;
               rsp_run_handle_in = '0;
               rsp_last_in       = 1'b1;
               state_in          = S_IDLE;
            end
         end

         // search for the target id
         S_DF_RD: begin
            if (idx_ff >= count_ff) begin
               rsp_strobe_in     = 1'b1;
               rsp_status_in     = ST_NOT_FOUND;
               rsp_result_id_in  = target_ff;
               rsp_run_handle_in = '0;
               rsp_last_in       = 1'b1;
               state_in          = S_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff[IDX_W-1:0];
               state_in    = S_DF_CHK;
            end
         end

         S_DF_CHK: begin
            if (rd_entry.id == target_ff) begin
               pos_in   = idx_ff;
               nd_in    = rd_entry.delta;
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_RM_RD;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_DF_RD;
            end
         end

         // shift the tail down over the removed slot, folding its delta
         S_RM_RD: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
               if (act_ff == ACT_DISPATCH) begin
                  if (period_ff != '0) begin
                     new_id_in  = next_id_ff;
                     next_id_in = next_id_ff + 32'd1;
                     delay_in   = period_ff;
                     idx_in     = '0;
                     sum_in     = '0;
                     state_in   = S_AW_RD;
                  end else begin
                     state_in = S_DP_RD;
                  end
               end else begin
                  rsp_strobe_in     = 1'b1;
                  rsp_status_in     = ST_OK;
                  rsp_result_id_in  = target_ff;
                  rsp_run_handle_in = '0;
                  rsp_last_in       = 1'b1;
                  state_in          = S_IDLE;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff[IDX_W-1:0];
               state_in    = S_RM_WR;
            end
         end

         S_RM_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = IDX_W'(idx_ff - CNT_W'(1));
            if (idx_ff == pos_next) begin
               ram_wr_entry.delta = rd_entry.delta + nd_ff;
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_RM_RD;
         end

         // count the head delay down
         S_TK_RD: begin
            if (count_ff == '0) begin
               rsp_strobe_in     = 1'b1;
               rsp_status_in     = ST_OK;
               rsp_result_id_in  = '0;
               rsp_run_handle_in = '0;
               rsp_last_in       = 1'b1;
               state_in          = S_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = S_TK_WR;
            end
         end

         S_TK_WR: begin
            if (rd_entry.delta != '0) begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = '0;
               ram_wr_entry.delta = rd_entry.delta - 32'd1;
            end
            rsp_strobe_in     = 1'b1;
            rsp_status_in     = ST_OK;
            rsp_result_id_in  = '0;
            rsp_run_handle_in = '0;
            rsp_last_in       = 1'b1;
            state_in          = S_IDLE;
         end

         // look at the head for a due task
         S_DP_RD: begin
            if (count_ff == '0) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_status_in     = ST_DISPATCHED;
                  rsp_result_id_in  = pend_id_ff;
                  rsp_run_handle_in = pend_handle_ff;
                  rsp_last_in       = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = S_DP_CHK;
            end
         end

         // hold one due word back so the last one can be flagged
         S_DP_CHK: begin
            if (pend_valid_ff) begin
               rsp_strobe_in     = 1'b1;
               rsp_status_in     = ST_DISPATCHED;
               rsp_result_id_in  = pend_id_ff;
               rsp_run_handle_in = pend_handle_ff;
               rsp_last_in       = (rd_entry.delta != '0);
            end
            if (rd_entry.delta != '0) begin
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end else begin
               pend_valid_in  = 1'b1;
               pend_id_in     = rd_entry.id;
               pend_handle_in = rd_entry.handle;
               handle_in      = rd_entry.handle;
               period_in      = rd_entry.period;
               pos_in         = '0;
               nd_in          = rd_entry.delta;
               idx_in         = CNT_W'(1);
               state_in       = S_RM_RD;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         next_id_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_id_ff    <= next_id_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff            <= act_in;
      handle_ff         <= handle_in;
      delay_ff          <= delay_in;
      period_ff         <= period_in;
      target_ff         <= target_in;
      new_id_ff         <= new_id_in;
      idx_ff            <= idx_in;
      pos_ff            <= pos_in;
      sum_ff            <= sum_in;
      nd_ff             <= nd_in;
      pend_id_ff        <= pend_id_in;
      pend_handle_ff    <= pend_handle_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_result_id_ff  <= rsp_result_id_in;
      rsp_run_handle_ff <= rsp_run_handle_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_id   = rsp_result_id_ff;
   assign rsp_run_handle  = rsp_run_handle_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

[rtl/dls_checker.sv]
// Port-level checks for the delta list task scheduler, bound to the top level.
module dls_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_result_id,
   input logic [7:0]  rsp_run_handle,
   input logic        rsp_last_of_run
);

   import dls_pkg::*;

   // an accepted word either starts a walk or is answered straight away
   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted word left no trace");

   // the closing word of an item is shown once the block is free again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_run |-> !busy)
      else $error("last word shown while busy");

   // a word that is not the last belongs to a dispatch still in progress
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_run |-> busy && rsp_status == ST_DISPATCHED)
      else $error("non-final word outside a dispatch");

   // add, delete and tick answer with exactly one word
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_DISPATCHED |-> rsp_last_of_run && rsp_run_handle == '0)
      else $error("single-word answer malformed");

   // a full table hands out no id
   a_full_id: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_FULL |-> rsp_result_id == '0)
      else $error("full table answer carries an id");

endmodule

bind delta_list_task_scheduler_top dls_checker u_dls_checker (.*);

[test/testbench.sv]
// Self-checking testbench for the delta list task scheduler.
`timescale 1ns / 1ps

module testbench;
   import dls_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [7:0]  req_task_handle;
   logic [31:0] req_start_delay;
   logic [31:0] req_repeat_period;
   logic [31:0] req_target_id;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_result_id;
   logic [7:0]  rsp_run_handle;
   logic        rsp_last_of_run;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] id;
      logic [7:0]  handle;
      logic        last;
   } word_type;

   // shadow copy of the delta list
   logic [7:0]  sh_handle [MAX_TASKS];
   logic [31:0] sh_id     [MAX_TASKS];
   logic [31:0] sh_delta  [MAX_TASKS];
   logic [31:0] sh_period [MAX_TASKS];
   int unsigned sh_count;
   logic [31:0] sh_next_id;

   word_type    expected_words [$];
   int          error_count;
   int          word_count;
   int          dispatch_count;
   int          item_count;
   longint      cycle_count;

   delta_list_task_scheduler_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit: a few hundred items in all; a hung run is stopped and fails
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // shift entries up and place a new one at pos
   function automatic void list_insert(input int unsigned pos, input logic [7:0] h,
                                       input logic [31:0] id, input logic [31:0] d,
                                       input logic [31:0] p);
      if (pos > sh_count || sh_count >= MAX_TASKS) return;
      for (int unsigned i = sh_count; i > pos; i--) begin
         sh_handle[i] = sh_handle[i-1];
         sh_id[i]     = sh_id[i-1];
         sh_delta[i]  = sh_delta[i-1];
         sh_period[i] = sh_period[i-1];
      end
      sh_handle[pos] = h;
      sh_id[pos]     = id;
      sh_delta[pos]  = d;
      sh_period[pos] = p;
      sh_count++;
   endfunction

   // unlink an entry, folding its delta into the successor
   function automatic void list_remove(input int unsigned pos);
      if (pos >= sh_count) return;
      if (pos + 1 < sh_count) sh_delta[pos+1] += sh_delta[pos];
      for (int unsigned i = pos; i + 1 < sh_count; i++) begin
         sh_handle[i] = sh_handle[i+1];
         sh_id[i]     = sh_id[i+1];
         sh_delta[i]  = sh_delta[i+1];
         sh_period[i] = sh_period[i+1];
      end
      sh_count--;
   endfunction

   // insert in due order; returns 0 on a full table
   function automatic bit list_add(input logic [7:0] h, input logic [31:0] delay,
                                   input logic [31:0] period, output logic [31:0] id);
      int unsigned i;
      logic [63:0] sum;
      logic [31:0] nd;
      id = '0;
      if (sh_count >= MAX_TASKS) return 0;
      id = sh_next_id;
      sh_next_id = sh_next_id + 1;
      if (sh_count == 0) begin
         list_insert(0, h, id, delay, period);
         return 1;
      end
      if (delay < sh_delta[0]) begin
         sh_delta[0] -= delay;
         list_insert(0, h, id, delay, period);
         return 1;
      end
      sum = 0;
      i = 0;
      forever begin
         sum += sh_delta[i];
         if ({32'd0, delay} == sum) begin
            nd = 0;
            break;
         end
         if (i + 1 >= sh_count) begin
            nd = 32'({32'd0, delay} - sum);
            break;
         end
         if (sum + sh_delta[i+1] > {32'd0, delay}) begin
            nd = 32'({32'd0, delay} - sum);
            sh_delta[i+1] -= nd;
            break;
         end
         i++;
      end
      list_insert(i + 1, h, id, nd, period);
      return 1;
   endfunction

   // work out the words one request causes and queue them
   function automatic void predict_words(input logic [1:0] act, input logic [7:0] h,
                                         input logic [31:0] delay,
                                         input logic [31:0] period,
                                         input logic [31:0] target);
      word_type w [$];
      logic [31:0] id;
      int unsigned i;
      logic [7:0] rh;
      logic [31:0] rp;
      case (act)
         ACT_ADD: begin
            if (list_add(h, delay, period, id)) w.push_back('{ST_OK, id, 8'd0, 1'b0});
            else w.push_back('{ST_FULL, 32'd0, 8'd0, 1'b0});
         end
         ACT_DELETE: begin
            for (i = 0; i < sh_count; i++)
               if (sh_id[i] == target) break;
            if (i < sh_count) begin
               list_remove(i);
               w.push_back('{ST_OK, target, 8'd0, 1'b0});
            end else begin
               w.push_back('{ST_NOT_FOUND, target, 8'd0, 1'b0});
            end
         end
         ACT_TICK: begin
            if (sh_count > 0 && sh_delta[0] != 0) sh_delta[0]--;
            w.push_back('{ST_OK, 32'd0, 8'd0, 1'b0});
         end
         default: begin
            for (i = 0; i < sh_count && sh_delta[i] == 0; i++)
               w.push_back('{ST_DISPATCHED, sh_id[i], sh_handle[i], 1'b0});
            while (sh_count > 0 && sh_delta[0] == 0) begin
               rh = sh_handle[0];
               rp = sh_period[0];
               list_remove(0);
               if (rp != 0) void'(list_add(rh, rp, rp, id));
            end
         end
      endcase
      if (w.size() > 0) w[w.size()-1].last = 1'b1;
      foreach (w[k]) expected_words.push_back(w[k]);
   endfunction

   // send one request, with a random gap beforehand; called on a falling edge
   task automatic send_item(input logic [1:0] act, input logic [7:0] h,
                            input logic [31:0] delay, input logic [31:0] period,
                            input logic [31:0] target, input bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 8) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      // drop start for the gap, or keep it high for a word straight after
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start             <= 1'b1;
      req_action        <= act;
      req_task_handle   <= h;
      req_start_delay   <= delay;
      req_repeat_period <= period;
      req_target_id     <= target;
      do @(posedge clock); while (busy);
      predict_words(act, h, delay, period, target);
      item_count++;
      @(negedge clock);
   endtask

   // check each word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         word_type e;
         word_count++;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word status %0d id %0h", rsp_status, rsp_result_id));
         end else begin
            e = expected_words.pop_front();
            if (rsp_status == ST_DISPATCHED) dispatch_count++;
            if (rsp_status !== e.status)
               report($sformatf("status %0d, want %0d", rsp_status, e.status));
            if (rsp_result_id !== e.id)
               report($sformatf("result_id %0h, want %0h", rsp_result_id, e.id));
            if (rsp_run_handle !== e.handle)
               report($sformatf("run_handle %0h, want %0h", rsp_run_handle, e.handle));
            if (rsp_last_of_run !== e.last)
               report($sformatf("last_of_run %0b, want %0b", rsp_last_of_run, e.last));
         end
      end
   end

   // release start and let every expected word come out
   task automatic drain;
      start <= 1'b0;
      while (expected_words.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   // add, delete, tick, dispatch basics, field extremes and equal due times
   task automatic test_directed;
      send_item(ACT_DISPATCH, 8'h00, 0, 0, 0);           // empty list
      send_item(ACT_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_ADD, 8'hFF, 3, 0, 32'hFFFF_FFFF);
      send_item(ACT_ADD, 8'h00, 3, 2, 0);                 // same due time
      send_item(ACT_ADD, 8'hA5, 1, 0, 0);                 // new head
      send_item(ACT_ADD, 8'h5A, 3, 0, 0);                 // same due again
      send_item(ACT_ADD, 8'h11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_item(ACT_DELETE, 8'h00, 0, 0, 32'hDEAD_BEEF);  // unknown id
      send_item(ACT_DELETE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2);
      repeat (4) send_item(ACT_TICK, 0, 0, 0, 0);         // includes tick on due head
      send_item(ACT_DISPATCH, 0, 0, 0, 0);
      send_item(ACT_TICK, 0, 0, 0, 0);
      send_item(ACT_TICK, 0, 0, 0, 0);
      send_item(ACT_DISPATCH, 0, 0, 0, 0);                // periodic re-add
      drain();
   endtask

   // fill the table, overflow it, dispatch the lot at once, then refill and dispatch again
   task automatic test_full_table;
      logic [31:0] p;
      while (sh_count < MAX_TASKS) send_item(ACT_ADD, 8'($urandom), 0, 0, 0, 0);
      send_item(ACT_ADD, 8'h77, 5, 5, 0);
      send_item(ACT_DISPATCH, 0, 0, 0, 0);
      while (sh_count < MAX_TASKS) begin
         p = $urandom_range(0, 1);
         send_item(ACT_ADD, 8'($urandom), 0, p, 0);
      end
      send_item(ACT_DISPATCH, 0, 0, 0, 0);                // periodic ones re-add when full
      drain();
   endtask

   // mostly short delays so ticks and dispatches matter; some wide values
   task automatic test_random;
      logic [1:0]  act;
      logic [31:0] d, p, t;
      int unsigned r;
      for (int n = 0; n < 180; n++) begin
         r = $urandom_range(0, 99);
         act = r < 35 ? ACT_ADD : r < 50 ? ACT_DELETE : r < 80 ? ACT_TICK : ACT_DISPATCH;
         d = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 6);
         p = $urandom_range(0, 2) == 0 ? 0 :
             ($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 6));
         if (sh_count > 0 && $urandom_range(0, 3) != 0)
            t = sh_id[$urandom_range(0, sh_count - 1)];
         else
            t = $urandom;
         send_item(act, 8'($urandom), d, p, t);
      end
      drain();
   endtask

   // empty the list, then add and delete a few tasks on the empty list
   task automatic test_id_wrap;
      logic [31:0] id;
      while (sh_count > 0) send_item(ACT_DELETE, 0, 0, 0, sh_id[0], 0);
      drain();
      for (int n = 0; n < 6; n++) begin
         id = sh_next_id;
         send_item(ACT_ADD, 8'($urandom), $urandom_range(0, 2), 0, 0, 0);
         send_item(ACT_DELETE, 0, 0, 0, id, 0);
      end
      drain();
   endtask

   initial begin
      error_count = 0; word_count = 0; dispatch_count = 0; item_count = 0;
      cycle_count = 0;
      sh_count = 0; sh_next_id = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         sh_handle[i] = '0; sh_id[i] = '0; sh_delta[i] = '0; sh_period[i] = '0;
      end
      reset = 1'b1; start = 1'b0;
      req_action = ACT_TICK; req_task_handle = '0; req_start_delay = '0;
      req_repeat_period = '0; req_target_id = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random();
      test_id_wrap();
      $display("covered %0d requests, %0d result words, %0d dispatched tasks",
               item_count, word_count, dispatch_count);
      $display("adds, deletes, ticks, dispatches, full table and equal due times");
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (expected_words.size() > 0)
            $display("%0d expected words never arrived", expected_words.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
